// File: hdl/time_ordered_event_queue_macros.svh
// assertion helpers shared by the checker
`ifndef TIME_ORDERED_EVENT_QUEUE_MACROS_SVH
`define TIME_ORDERED_EVENT_QUEUE_MACROS_SVH

// same-cycle implication, off while in reset
`define TOEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define TOEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/toeq_pkg.sv
package toeq_pkg;

  localparam int unsigned TIME_W = 64;
  localparam int unsigned CFG_W  = 16;

  localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_FLUSH  = 2'd3
  } toeq_cmd_e;

  typedef enum logic [1:0] {
    DIR_ALWAYS = 2'd0,
    DIR_BEFORE = 2'd1,
    DIR_AT     = 2'd2,
    DIR_AFTER  = 2'd3
  } toeq_dir_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_TYPE  = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } toeq_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } toeq_state_e;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    toeq_cmd_e cmd;
    toeq_dir_e dir;
    logic      inclusive;
    logic      any_type;
    logic      eval;
    logic      ins;
    logic      rm;
  } toeq_ctl_t;

endpackage

// File: hdl/toeq_req_if.sv
interface toeq_req_if #(
  parameter int unsigned TYPE_BITS = 16,
  parameter int unsigned TAG_BITS  = 32
);
  import toeq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic signed [TIME_W-1:0] ev_stamp;
  logic [TYPE_BITS-1:0]     event_type;
  logic [TAG_BITS-1:0]      event_tag;
  logic signed [TIME_W-1:0] match_time;
  logic [1:0]               direction;
  logic                     inclusive;
  logic [TYPE_BITS-1:0]     match_type;
  logic                     any_type;

  modport source (
    output valid, command, ev_stamp, event_type, event_tag,
           match_time, direction, inclusive, match_type, any_type,
    input  ready
  );
  modport sink (
    input  valid, command, ev_stamp, event_type, event_tag,
           match_time, direction, inclusive, match_type, any_type,
    output ready
  );
endinterface

// File: hdl/toeq_res_if.sv
interface toeq_res_if #(
  parameter int unsigned TYPE_BITS = 16,
  parameter int unsigned TAG_BITS  = 32,
  parameter int unsigned CNT_W     = 6
);
  import toeq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [TIME_W-1:0] out_time;
  logic [TYPE_BITS-1:0]     out_type;
  logic [TAG_BITS-1:0]      out_tag;
  logic                     last;
  logic [CNT_W-1:0]         queue_count;
  logic signed [TIME_W-1:0] head_time;
  logic                     empty_res;

  modport source (
    output valid, status, out_time, out_type, out_tag, last,
           queue_count, head_time, empty_res,
    input  ready
  );
  modport sink (
    input  valid, status, out_time, out_type, out_tag, last,
           queue_count, head_time, empty_res,
    output ready
  );
endinterface

// File: hdl/toeq_cfg_if.sv
interface toeq_cfg_if;
  import toeq_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hdl/toeq_cell.sv
module toeq_cell #(
  parameter int unsigned TYPE_BITS = 16,
  parameter int unsigned TAG_BITS  = 32
) (
  input  logic                               clk_i,
  input  toeq_pkg::toeq_ctl_t                ctl_i,
  input  logic                               valid_i,
  input  logic signed [toeq_pkg::TIME_W-1:0] new_time_i,
  input  logic [TYPE_BITS-1:0]               new_type_i,
  input  logic [TAG_BITS-1:0]                new_tag_i,
  input  logic signed [toeq_pkg::TIME_W-1:0] match_time_i,
  input  logic [TYPE_BITS-1:0]               match_type_i,
  input  logic signed [toeq_pkg::TIME_W-1:0] left_time_i,
  input  logic [TYPE_BITS-1:0]               left_type_i,
  input  logic [TAG_BITS-1:0]                left_tag_i,
  input  logic                               left_flag_i,
  input  logic signed [toeq_pkg::TIME_W-1:0] right_time_i,
  input  logic [TYPE_BITS-1:0]               right_type_i,
  input  logic [TAG_BITS-1:0]                right_tag_i,
  input  logic                               right_flag_i,
  input  logic                               found_i,
  input  logic                               two_i,
  output logic signed [toeq_pkg::TIME_W-1:0] time_o,
  output logic [TYPE_BITS-1:0]               type_o,
  output logic [TAG_BITS-1:0]                tag_o,
  output logic                               flag_o,
  output logic                               found_o,
  output logic                               two_o,
  output logic                               sel_o
);
  import toeq_pkg::*;

  logic signed [TIME_W-1:0] time_q, time_d;
  logic [TYPE_BITS-1:0]     type_q, type_d;
  logic [TAG_BITS-1:0]      tag_q, tag_d;
  logic                     flag_q, flag_d;
  logic                     hit;
  logic                     t_lt, t_eq, t_gt, pass;

  // flag: insert-here for add, match for the removing commands
  always_comb begin
    t_lt = time_q < match_time_i;
    t_eq = time_q == match_time_i;
    t_gt = time_q > match_time_i;
    case (ctl_i.dir)
      DIR_ALWAYS: pass = 1'b1;
      DIR_BEFORE: pass = t_lt || (t_eq && ctl_i.inclusive);
      DIR_AT:     pass = t_eq;
      DIR_AFTER:  pass = t_gt || (t_eq && ctl_i.inclusive);
      default:    pass = 1'b1;
    endcase
    pass = pass && (ctl_i.any_type || (type_q == match_type_i));
    case (ctl_i.cmd)
      CMD_ADD:    hit = !valid_i || (new_time_i < time_q);
      CMD_POP:    hit = valid_i;
      CMD_REMOVE: hit = valid_i && (time_q == new_time_i) && (type_q == new_type_i)
                        && (tag_q == new_tag_i);
      CMD_FLUSH:  hit = valid_i && pass;
      default:    hit = 1'b0;
    endcase
  end

  assign found_o = found_i || flag_q;
  assign two_o   = two_i || (found_i && flag_q);
  assign sel_o   = flag_q && !found_i;

  always_comb begin
    time_d = time_q;
    type_d = type_q;
    tag_d  = tag_q;
    flag_d = flag_q;
    if (ctl_i.eval) begin
      flag_d = hit;
    end else if (ctl_i.ins && flag_q) begin
      if (left_flag_i) begin
        time_d = left_time_i;
        type_d = left_type_i;
        tag_d  = left_tag_i;
      end else begin
        time_d = new_time_i;
        type_d = new_type_i;
        tag_d  = new_tag_i;
      end
    end else if (ctl_i.rm && found_o) begin
      time_d = right_time_i;
      type_d = right_type_i;
      tag_d  = right_tag_i;
      flag_d = right_flag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    type_q <= type_d;
    tag_q  <= tag_d;
    flag_q <= flag_d;
  end

  assign time_o = time_q;
  assign type_o = type_q;
  assign tag_o  = tag_q;
  assign flag_o = flag_q;

endmodule

// File: hdl/time_ordered_event_queue.sv
// channel | role   | moves
// cfg_i   | sink   | min_valid_type write (always ready)
// req_i   | sink   | one command request
// res_o   | source | one result per request, several for a flush
//
// a request is latched, evaluated in every cell in the next cycle (compare flags),
// and applied in the cycle after, when the result register is free
// for add, pop and remove the next request can be taken in the apply cycle
// a flush gives one result per match, at least one; the single result register
// passes one result per cycle while the receiver is ready
// a stalled result holds the apply step; no clearing pass is needed after reset
module time_ordered_event_queue #(
  parameter int unsigned DEPTH     = 32,
  parameter int unsigned TYPE_BITS = 16,
  parameter int unsigned TAG_BITS  = 32
) (
  input logic           clk_i,
  input logic           rst_ni,
  toeq_cfg_if.sink      cfg_i,
  toeq_req_if.sink      req_i,
  toeq_res_if.source    res_o
);
  import toeq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (TYPE_BITS > CFG_W) ? TYPE_BITS : CFG_W;

  // sequencer and held state
  toeq_state_e      state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CFG_W-1:0] min_q;

  // latched request
  toeq_cmd_e                cmd_q;
  logic signed [TIME_W-1:0] ev_time_q;
  logic [TYPE_BITS-1:0]     ev_type_q;
  logic [TAG_BITS-1:0]      ev_tag_q;
  logic signed [TIME_W-1:0] m_time_q;
  toeq_dir_e                dir_q;
  logic                     incl_q;
  logic [TYPE_BITS-1:0]     m_type_q;
  logic                     any_q;

  // result register
  logic                     out_valid_q, out_valid_d;
  toeq_status_e             out_status_q, out_status_d;
  logic signed [TIME_W-1:0] out_time_q, out_time_d;
  logic [TYPE_BITS-1:0]     out_type_q, out_type_d;
  logic [TAG_BITS-1:0]      out_tag_q, out_tag_d;
  logic                     out_last_q, out_last_d;
  logic [CNT_W-1:0]         out_count_q, out_count_d;
  logic signed [TIME_W-1:0] out_head_q, out_head_d;

  // cell row
  toeq_ctl_t                ctl;
  logic signed [TIME_W-1:0] c_time [DEPTH];
  logic [TYPE_BITS-1:0]     c_type [DEPTH];
  logic [TAG_BITS-1:0]      c_tag  [DEPTH];
  logic [DEPTH-1:0]         c_flag, c_found, c_two, c_sel;

  logic                     out_free, apply_go, done, accept;
  logic                     add_bad, add_full, add_ok, any_hit;
  logic signed [TIME_W-1:0] sel_time;
  logic [TYPE_BITS-1:0]     sel_type;
  logic [TAG_BITS-1:0]      sel_tag;
  logic [CNT_W-1:0]         cnt_after;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= CFG_W'(1);
    end else if (cfg_i.valid) begin
      min_q <= cfg_i.data;
    end
  end

  // the row of cells; slot 0 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [TIME_W-1:0] l_time, r_time;
    logic [TYPE_BITS-1:0]     l_type, r_type;
    logic [TAG_BITS-1:0]      l_tag, r_tag;
    logic                     l_flag, r_flag, f_in, t_in;

    if (i == 0) begin : g_head
      assign l_time = '0;
      assign l_type = '0;
      assign l_tag  = '0;
      assign l_flag = 1'b0;
      assign f_in   = 1'b0;
      assign t_in   = 1'b0;
    end else begin : g_body
      assign l_time = c_time[i-1];
      assign l_type = c_type[i-1];
      assign l_tag  = c_tag[i-1];
      assign l_flag = c_flag[i-1];
      assign f_in   = c_found[i-1];
      assign t_in   = c_two[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // nothing shifts in behind the last slot
      assign r_time = '0;
      assign r_type = '0;
      assign r_tag  = '0;
      assign r_flag = 1'b0;
    end else begin : g_inner
      assign r_time = c_time[i+1];
      assign r_type = c_type[i+1];
      assign r_tag  = c_tag[i+1];
      assign r_flag = c_flag[i+1];
    end

    toeq_cell #(
      .TYPE_BITS (TYPE_BITS),
      .TAG_BITS  (TAG_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .valid_i      (CNT_W'(i) < count_q),
      .new_time_i   (ev_time_q),
      .new_type_i   (ev_type_q),
      .new_tag_i    (ev_tag_q),
      .match_time_i (m_time_q),
      .match_type_i (m_type_q),
      .left_time_i  (l_time),
      .left_type_i  (l_type),
      .left_tag_i   (l_tag),
      .left_flag_i  (l_flag),
      .right_time_i (r_time),
      .right_type_i (r_type),
      .right_tag_i  (r_tag),
      .right_flag_i (r_flag),
      .found_i      (f_in),
      .two_i        (t_in),
      .time_o       (c_time[i]),
      .type_o       (c_type[i]),
      .tag_o        (c_tag[i]),
      .flag_o       (c_flag[i]),
      .found_o      (c_found[i]),
      .two_o        (c_two[i]),
      .sel_o        (c_sel[i])
    );
  end

  // one-hot pick of the first matching slot
  always_comb begin
    sel_time = '0;
    sel_type = '0;
    sel_tag  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_time = sel_time | (c_sel[i] ? c_time[i] : '0);
      sel_type = sel_type | (c_sel[i] ? c_type[i] : '0);
      sel_tag  = sel_tag | (c_sel[i] ? c_tag[i] : '0);
    end
  end

  assign out_free = !out_valid_q || res_o.ready;
  assign apply_go = (state_q == S_APPLY) && out_free;
  assign any_hit  = c_found[DEPTH-1];
  // a flush carries on while a second match is still in the row
  assign done     = (cmd_q != CMD_FLUSH) || !c_two[DEPTH-1];
  assign add_bad  = CMP_W'(ev_type_q) < CMP_W'(min_q);
  assign add_full = count_q == CNT_W'(DEPTH);
  assign add_ok   = !add_bad && !add_full;
  assign cnt_after = count_q - CNT_W'(1);

  assign req_i.ready = (state_q == S_IDLE) || (apply_go && done);
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    ctl.cmd       = cmd_q;
    ctl.dir       = dir_q;
    ctl.inclusive = incl_q;
    ctl.any_type  = any_q;
    ctl.eval      = state_q == S_EVAL;
    ctl.ins       = apply_go && (cmd_q == CMD_ADD) && add_ok;
    ctl.rm        = apply_go && (cmd_q != CMD_ADD);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: state_d = S_APPLY;
      S_APPLY: begin
        if (apply_go && done) begin
          state_d = accept ? S_EVAL : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result and count update
  always_comb begin
    count_d      = count_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_status_d = out_status_q;
    out_time_d   = out_time_q;
    out_type_d   = out_type_q;
    out_tag_d    = out_tag_q;
    out_last_d   = out_last_q;
    out_count_d  = out_count_q;
    out_head_d   = out_head_q;
    if (apply_go) begin
      out_valid_d = 1'b1;
      out_last_d  = done;
      out_time_d  = '0;
      out_type_d  = '0;
      out_tag_d   = '0;
      out_count_d = count_q;
      out_head_d  = (count_q == '0) ? TIME_MAX : c_time[0];
      if (cmd_q == CMD_ADD) begin
        if (add_bad) begin
          out_status_d = STAT_BAD_TYPE;
        end else if (add_full) begin
          out_status_d = STAT_FULL;
        end else begin
          out_status_d = STAT_OK;
          count_d      = count_q + CNT_W'(1);
          out_count_d  = count_d;
          // the new event becomes head when it lands in slot 0
          out_head_d   = c_flag[0] ? ev_time_q : c_time[0];
        end
      end else if (any_hit) begin
        out_status_d = STAT_OK;
        out_time_d   = sel_time;
        out_type_d   = sel_type;
        out_tag_d    = sel_tag;
        count_d      = cnt_after;
        out_count_d  = cnt_after;
        if (cnt_after == '0) begin
          out_head_d = TIME_MAX;
        end else begin
          out_head_d = c_sel[0] ? c_time[1] : c_time[0];
        end
      end else begin
        out_status_d = STAT_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_time_q   <= out_time_d;
    out_type_q   <= out_type_d;
    out_tag_q    <= out_tag_d;
    out_last_q   <= out_last_d;
    out_count_q  <= out_count_d;
    out_head_q   <= out_head_d;
    if (accept) begin
      cmd_q     <= toeq_cmd_e'(req_i.command);
      ev_time_q <= req_i.ev_stamp;
      ev_type_q <= req_i.event_type;
      ev_tag_q  <= req_i.event_tag;
      m_time_q  <= req_i.match_time;
      dir_q     <= toeq_dir_e'(req_i.direction);
      incl_q    <= req_i.inclusive;
      m_type_q  <= req_i.match_type;
      any_q     <= req_i.any_type;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_status_q;
  assign res_o.out_time    = out_time_q;
  assign res_o.out_type    = out_type_q;
  assign res_o.out_tag     = out_tag_q;
  assign res_o.last        = out_last_q;
  assign res_o.queue_count = out_count_q;
  assign res_o.head_time   = out_head_q;
  assign res_o.empty_res   = out_count_q == '0;

endmodule

// File: hdl/toeq_checker.sv
`include "time_ordered_event_queue_macros.svh"

module toeq_checker #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned CNT_W = 6
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               res_valid_i,
  input logic                               res_ready_i,
  input logic [1:0]                         status_i,
  input logic signed [toeq_pkg::TIME_W-1:0] out_time_i,
  input logic                               last_i,
  input logic [CNT_W-1:0]                   queue_count_i,
  input logic signed [toeq_pkg::TIME_W-1:0] head_time_i,
  input logic                               empty_res_i
);
  import toeq_pkg::*;

  `TOEQ_ASSERT_NXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(status_i) && $stable(out_time_i) && $stable(last_i), "stalled result changed")
  `TOEQ_ASSERT_IMP(a_empty_count, clk_i, rst_ni, res_valid_i, empty_res_i == (queue_count_i == '0), "empty flag disagrees with count")
  `TOEQ_ASSERT_IMP(a_empty_head, clk_i, rst_ni, res_valid_i && empty_res_i, head_time_i == TIME_MAX, "empty queue head time not maximum")
  `TOEQ_ASSERT_IMP(a_count_max, clk_i, rst_ni, res_valid_i, queue_count_i <= CNT_W'(DEPTH), "count above depth")
  `TOEQ_ASSERT_IMP(a_err_last, clk_i, rst_ni, res_valid_i && (status_i != STAT_OK), last_i, "error result not final")

endmodule

bind time_ordered_event_queue toeq_checker #(
  .DEPTH (DEPTH),
  .CNT_W ($clog2(DEPTH + 1))
) u_toeq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .status_i      (res_o.status),
  .out_time_i    (res_o.out_time),
  .last_i        (res_o.last),
  .queue_count_i (res_o.queue_count),
  .head_time_i   (res_o.head_time),
  .empty_res_i   (res_o.empty_res)
);
